@@ hdl/pcc_pkg.sv @@
// Shared constants and transaction types for the profile consensus counter.
package pcc_pkg;

  localparam int COLUMNS    = 1024;
  localparam int COL_IDX_W  = $clog2(COLUMNS);
  localparam int COL_W      = 10;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 8;
  localparam int COUNT_CEIL = 255;
  localparam int NUM_BASES  = 4;
  localparam int SLOT_W     = 2;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  // slot order: A, C, G, T
  localparam logic [NUM_BASES-1:0][CHAR_W-1:0] LETTERS = {CHAR_T, CHAR_G, CHAR_C, CHAR_A};

  typedef logic [NUM_BASES-1:0][CNT_W-1:0] counts_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] base;
    logic              first_row;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic [CNT_W-1:0]  count_a;
    logic [CNT_W-1:0]  count_c;
    logic [CNT_W-1:0]  count_g;
    logic [CNT_W-1:0]  count_t;
    logic [CHAR_W-1:0] consensus_letter;
  } out_t;

endpackage

@@ hdl/pcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/profile_consensus_counter_top.sv @@
// Top level of the profile consensus counter: column count store and consensus pick.
//
// Accepts one base per clock: busy is held low, so a transaction is taken at
// every edge where start is high. Each transaction yields exactly one result,
// shown on out_data with out_valid high for one cycle: the accepting edge
// registers the transaction and reads the column's counts from the RAM; the
// updated counts and the consensus are registered into the result register.
// The receiver cannot stall; results stream out at the input rate. Throughput
// is one transaction per cycle, set by the single-port-read / single-port-write
// count RAM; a column hit by back-to-back transactions gets its counts from a
// one-entry bypass of the last write. The count RAM is not cleared by reset:
// each column must be started by a first-row transaction before it is counted
// into, otherwise the counts reported for it are meaningless. Column indexes
// wrap modulo the column count; column_out echoes the input column.
module profile_consensus_counter_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pcc_pkg::in_t  in_data,
  output logic          out_valid,
  output pcc_pkg::out_t out_data
);

  // read stage
  logic                                  s1_valid_r;
  pcc_pkg::in_t                          s1_item_r;
  logic [pcc_pkg::COL_IDX_W-1:0]         s1_idx;
  pcc_pkg::counts_t                      ram_rdata;

  // bypass of the most recent write
  logic                                  fwd_valid_r;
  logic [pcc_pkg::COL_IDX_W-1:0]         fwd_idx_r;
  pcc_pkg::counts_t                      fwd_cnt_r;

  // update logic
  pcc_pkg::counts_t                      old_cnt;
  pcc_pkg::counts_t                      new_cnt;
  logic                                  slot_hit;
  logic [pcc_pkg::SLOT_W-1:0]            slot;
  logic [pcc_pkg::SLOT_W-1:0]            best;

  // result register
  logic                                  out_valid_r;
  pcc_pkg::out_t                         out_data_r;
  pcc_pkg::out_t                         out_data_nxt;

  logic                                  accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign s1_idx = s1_item_r.column[pcc_pkg::COL_IDX_W-1:0];

  pcc_ram #(
    .WIDTH ($bits(pcc_pkg::counts_t)),
    .DEPTH (pcc_pkg::COLUMNS)
  ) u_count_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_idx),
    .wdata (new_cnt),
    .raddr (in_data.column[pcc_pkg::COL_IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // base decode
  always_comb begin
    slot_hit = 1'b1;
    slot     = '0;
    case (s1_item_r.base)
      pcc_pkg::CHAR_A: slot = 2'd0;
      pcc_pkg::CHAR_C: slot = 2'd1;
      pcc_pkg::CHAR_G: slot = 2'd2;
      pcc_pkg::CHAR_T: slot = 2'd3;
      default:         slot_hit = 1'b0;
    endcase
  end

  // count update; RAM read misses a write from the previous cycle, so bypass it
  always_comb begin
    old_cnt = (fwd_valid_r && (fwd_idx_r == s1_idx)) ? fwd_cnt_r : ram_rdata;
    new_cnt = old_cnt;
    if (s1_item_r.first_row) begin
      new_cnt = '0;
      if (slot_hit) begin
        new_cnt[slot] = pcc_pkg::CNT_W'(1);
      end
    end else if (slot_hit) begin
      if (old_cnt[slot] < pcc_pkg::CNT_W'(pcc_pkg::COUNT_CEIL)) begin
        new_cnt[slot] = old_cnt[slot] + pcc_pkg::CNT_W'(1);
      end else begin
        new_cnt[slot] = pcc_pkg::CNT_W'(pcc_pkg::COUNT_CEIL);
      end
    end
  end

  // consensus: strict greater-than keeps ties on the earlier letter
  always_comb begin
    best = '0;
    for (int k = 1; k < pcc_pkg::NUM_BASES; k++) begin
      if (new_cnt[k] > new_cnt[best]) begin
        best = pcc_pkg::SLOT_W'(k);
      end
    end
  end

  always_comb begin
    out_data_nxt.column_out       = s1_item_r.column;
    out_data_nxt.count_a          = new_cnt[0];
    out_data_nxt.count_c          = new_cnt[1];
    out_data_nxt.count_g          = new_cnt[2];
    out_data_nxt.count_t          = new_cnt[3];
    out_data_nxt.consensus_letter = pcc_pkg::LETTERS[best];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      fwd_valid_r <= s1_valid_r;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_data;
    end
    if (s1_valid_r) begin
      fwd_idx_r  <= s1_idx;
      fwd_cnt_r  <= new_cnt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/profile_scoreboard_pkg.sv @@
`timescale 1ns / 100ps
// Scoreboard class: per-column count predictor and in-order result checker.
package profile_scoreboard_pkg;
  import pcc_pkg::*;

  typedef enum int {SLOT_A, SLOT_C, SLOT_G, SLOT_T, SLOT_NONE} base_slot_t;

  class profile_scoreboard;
    int unsigned col_counts [COLUMNS][NUM_BASES];
    out_t        expected_q [$];
    int          mismatches;
    int          results_checked;
    int          saturated_hits;
    int          fresh_columns;
    int          ignored_bytes;

    function base_slot_t slot_of(logic [CHAR_W-1:0] ch);
      case (ch)
        CHAR_A:  return SLOT_A;
        CHAR_C:  return SLOT_C;
        CHAR_G:  return SLOT_G;
        CHAR_T:  return SLOT_T;
        default: return SLOT_NONE;
      endcase
    endfunction

    // Update the column's profile and queue the result it must produce.
    function void note_input(in_t txn);
      int unsigned idx;
      base_slot_t  slot;
      int          best;
      out_t        want;
      idx  = txn.column % COLUMNS;
      slot = slot_of(txn.base);
      if (slot == SLOT_NONE) ignored_bytes++;
      if (txn.first_row) begin
        fresh_columns++;
        for (int k = 0; k < NUM_BASES; k++) col_counts[idx][k] = 0;
        if (slot != SLOT_NONE) col_counts[idx][int'(slot)] = (COUNT_CEIL >= 1) ? 1 : 0;
      end else if (slot != SLOT_NONE) begin
        if (col_counts[idx][int'(slot)] < COUNT_CEIL) begin
          col_counts[idx][int'(slot)]++;
        end else begin
          col_counts[idx][int'(slot)] = COUNT_CEIL;
          saturated_hits++;
        end
      end
      // ties keep the earlier letter
      best = 0;
      for (int k = 1; k < NUM_BASES; k++) begin
        if (col_counts[idx][k] > col_counts[idx][best]) best = k;
      end
      want.column_out       = txn.column;
      want.count_a          = CNT_W'(col_counts[idx][SLOT_A]);
      want.count_c          = CNT_W'(col_counts[idx][SLOT_C]);
      want.count_g          = CNT_W'(col_counts[idx][SLOT_G]);
      want.count_t          = CNT_W'(col_counts[idx][SLOT_T]);
      want.consensus_letter = LETTERS[best];
      expected_q.push_back(want);
    endfunction

    task report(string msg);
      $display("tb: mismatch: %s", msg);
      mismatches++;
    endtask

    task check_field(string name, logic [15:0] got, logic [15:0] want, logic [COL_W-1:0] col);
      if (got !== want) report($sformatf("column %0d %s got %0h want %0h", col, name, got, want));
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result for column %0d with nothing expected", got.column_out));
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      check_field("column_out", got.column_out, want.column_out, want.column_out);
      check_field("count_a", got.count_a, want.count_a, want.column_out);
      check_field("count_c", got.count_c, want.count_c, want.column_out);
      check_field("count_g", got.count_g, want.count_g, want.column_out);
      check_field("count_t", got.count_t, want.count_t, want.column_out);
      check_field("consensus_letter", got.consensus_letter, want.consensus_letter,
                  want.column_out);
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

@@ bench/profile_consensus_counter_top_test.sv @@
`timescale 1ns / 100ps
// Top-level bench for the profile consensus counter: stimulus, monitor and run control.
module profile_consensus_counter_top_test;
  import pcc_pkg::*;
  import profile_scoreboard_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_SAT_SETS = 2;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  profile_scoreboard sb;

  // Columns that a first-row transaction has written; only these may be
  // counted into, since the count RAM is not cleared by reset.
  bit col_started [COLUMNS];
  int items_sent;
  int cycles;
  int no_gap_left;  // remaining transactions of a back-to-back stretch

  profile_consensus_counter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: both channels are sampled at the edge, before any NBA lands.
  // The input is noted first, so the expectation exists whatever the latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_data);
      if (out_valid) sb.check_result(out_data);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles, %0d results pending", cycles, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // Drive one transaction after a random idle gap and wait for the handshake.
  // A zero gap leaves start high, so back-to-back transactions never glitch it.
  task send_item(logic [COL_W-1:0] col, logic [CHAR_W-1:0] ch, logic first);
    int   gap;
    in_t  txn;
    txn.column    = col;
    txn.base      = ch;
    txn.first_row = first;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      gap = 0;
      no_gap_left = $urandom_range(20, 60);
    end else begin
      gap = $urandom_range(0, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= txn;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    if (first) col_started[col] = 1'b1;
    items_sent++;
  endtask

  // Mostly nucleotide letters; the rest any byte, lower case and controls included.
  function logic [CHAR_W-1:0] random_base(int other_pct);
    if ($urandom_range(0, 99) < other_pct) return CHAR_W'($urandom);
    return LETTERS[$urandom_range(0, NUM_BASES - 1)];
  endfunction

  // One alignment: a first row that starts a run of columns, then more rows.
  // A few mid-set first-row flags break the set on purpose.
  task run_profile_set();
    logic [COL_W-1:0] first_col;
    int               width;
    int               rows;
    first_col = COL_W'($urandom);
    width     = $urandom_range(1, 12);
    rows      = $urandom_range(2, 10);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < width; c++) begin
        send_item(first_col + COL_W'(c), random_base(10),
                  (r == 0) || ($urandom_range(0, 99) < 3));
      end
    end
  endtask

  // Hammer one column with one letter until its count pins at the maximum.
  task run_saturation_set();
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    int                n;
    col = COL_W'($urandom);
    ch  = LETTERS[$urandom_range(0, NUM_BASES - 1)];
    n   = $urandom_range(COUNT_CEIL + 45, COUNT_CEIL + 85);
    send_item(col, ch, 1'b1);
    repeat (n) send_item(col, ($urandom_range(0, 9) == 0) ? random_base(50) : ch, 1'b0);
  endtask

  // Scattered noise: any column, any byte; unstarted columns are always started.
  task run_noise();
    logic [COL_W-1:0] col;
    repeat ($urandom_range(1, 8)) begin
      col = COL_W'($urandom);
      send_item(col, CHAR_W'($urandom), !col_started[col] || ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    int target;
    int sat_sets;
    int kind;
    sb = new();
    sat_sets = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: column extremes, ties, other bytes, fresh restarts, bypass hits.
    send_item(10'd0,    CHAR_A, 1'b1);
    send_item(10'd0,    CHAR_C, 1'b0);   // A/C tie goes to A
    send_item(10'd0,    CHAR_C, 1'b0);
    send_item(10'd1023, CHAR_T, 1'b1);
    send_item(10'd1023, CHAR_G, 1'b0);   // G/T tie goes to G
    send_item(10'd1023, 8'h78,  1'b0);   // other byte, counts unchanged
    send_item(10'd1023, 8'hFF,  1'b0);
    send_item(10'd512,  8'h00,  1'b1);   // fresh with other byte: all zero, letter A
    send_item(10'd512,  8'h61,  1'b0);   // lower case is not counted
    send_item(10'd512,  CHAR_G, 1'b0);
    send_item(10'd341,  CHAR_T, 1'b1);
    send_item(10'd682,  CHAR_C, 1'b1);
    send_item(10'd341,  CHAR_A, 1'b0);
    send_item(10'd0,    CHAR_G, 1'b1);   // restart of a counted column
    send_item(10'd0,    CHAR_T, 1'b0);
    send_item(10'd0,    CHAR_T, 1'b0);
    send_item(10'd7,    CHAR_A, 1'b1);
    send_item(10'd8,    CHAR_A, 1'b1);
    send_item(10'd7,    CHAR_A, 1'b0);   // same column two transactions back
    send_item(10'd5,    8'hFF,  1'b1);
    send_item(10'd5,    8'h00,  1'b0);
    send_item(10'd682,  CHAR_G, 1'b0);
    send_item(10'd682,  CHAR_T, 1'b0);

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 5 && sat_sets < MAX_SAT_SETS) begin
        sat_sets++;
        run_saturation_set();
      end else if (kind < 85) begin
        run_profile_set();
      end else begin
        run_noise();
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d transactions, %0d results checked, %0d fresh column starts",
             items_sent, sb.results_checked, sb.fresh_columns);
    $display("tb: %0d uncounted bytes, %0d increments held at saturation, %0d mismatches",
             sb.ignored_bytes, sb.saturated_hits, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pcc_pkg.sv
hdl/pcc_ram.sv
hdl/profile_consensus_counter_top.sv
bench/profile_scoreboard_pkg.sv
bench/profile_consensus_counter_top_test.sv
